>>> rtl/pid_pkg.sv
// Shared types, constants and the echo-to-distance conversion of the presence/idle detector.
package pid_pkg;

    // Echo samples per poll.
    localparam int SAMPLE_COUNT = 5;
    localparam int MID_IDX      = SAMPLE_COUNT / 2;
    localparam int RANK_W       = $clog2(SAMPLE_COUNT);

    localparam int ECHO_W = 15;
    localparam int DIST_W = 9;
    localparam int TIME_W = 32;
    localparam int CFG_W  = 32;
    localparam int IDX_W  = 3;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] CFG_IDLE_TIMEOUT = 3'd0;
    localparam logic [IDX_W-1:0] CFG_MOTION_HOLD  = 3'd1;
    localparam logic [IDX_W-1:0] CFG_SNOOZE_DUR   = 3'd2;
    localparam logic [IDX_W-1:0] CFG_NEAR_LIMIT   = 3'd3;
    localparam logic [IDX_W-1:0] CFG_FAR_LOW      = 3'd4;
    localparam logic [IDX_W-1:0] CFG_FAR_HIGH     = 3'd5;

    // Register reset values.
    localparam logic [TIME_W-1:0] RST_IDLE_TIMEOUT = 32'd20000;
    localparam logic [TIME_W-1:0] RST_MOTION_HOLD  = 32'd3000;
    localparam logic [TIME_W-1:0] RST_SNOOZE_DUR   = 32'd300000;
    localparam logic [DIST_W-1:0] RST_NEAR_LIMIT   = 9'd10;
    localparam logic [DIST_W-1:0] RST_FAR_LOW      = 9'd30;
    localparam logic [DIST_W-1:0] RST_FAR_HIGH     = 9'd500;

    typedef logic [ECHO_W-1:0] t_echo;
    typedef logic [DIST_W-1:0] t_dist;
    typedef logic [TIME_W-1:0] t_time;

    typedef struct packed {
        t_time idle_timeout_ms;
        t_time motion_hold_ms;
        t_time snooze_duration_ms;
        t_dist near_limit_cm;
        t_dist far_low_cm;
        t_dist far_high_cm;
    } t_cfg;

    // Item after echo conversion.
    typedef struct packed {
        logic                          pir_detect;
        t_dist [SAMPLE_COUNT-1:0]      dist_cm;
        logic                          button_pressed;
        logic                          timer_running;
        logic                          alarm_editing;
        logic                          alarm_beeping;
        t_time                         now_ms;
    } t_conv_item;

    typedef struct packed {
        t_dist distance_cm;
        logic  motion_present;
        logic  motion_started;
        logic  motion_ended;
        logic  idle_mode;
        logic  idle_exited;
        logic  idle_entered;
        logic  snooze_fired;
        t_time snooze_end_ms;
    } t_result;

    // floor(d*17/1000), saturated. The quotient uses the reciprocal 1048/2^20,
    // which lands on the true value or one below; one compare fixes it.
    function automatic t_dist echo_to_cm(input t_echo d);
        logic [19:0] x;
        logic [30:0] p;
        logic [9:0]  q;
        logic [19:0] r;
        x = 20'(d) * 20'd17;
        p = 31'(x) * 31'd1048;
        q = p[29:20];
        r = x - 20'(q) * 20'd1000;
        if (r >= 20'd1000) begin
            q = q + 10'd1;
        end
        if (q > 10'(DIST_MAX)) begin
            q = 10'(DIST_MAX);
        end
        return q[DIST_W-1:0];
    endfunction

endpackage

>>> rtl/pid_in_if.sv
// Input item channel of the presence/idle detector.
interface pid_in_if;
    logic            valid;
    logic            ready;
    logic            pir_detect;
    pid_pkg::t_echo  echo_0;
    pid_pkg::t_echo  echo_1;
    pid_pkg::t_echo  echo_2;
    pid_pkg::t_echo  echo_3;
    pid_pkg::t_echo  echo_4;
    logic            button_pressed;
    logic            timer_running;
    logic            alarm_editing;
    logic            alarm_beeping;
    pid_pkg::t_time  now_ms;

    modport source (
        output valid, pir_detect, echo_0, echo_1, echo_2, echo_3, echo_4,
               button_pressed, timer_running, alarm_editing, alarm_beeping, now_ms,
        input  ready
    );
    modport sink (
        input  valid, pir_detect, echo_0, echo_1, echo_2, echo_3, echo_4,
               button_pressed, timer_running, alarm_editing, alarm_beeping, now_ms,
        output ready
    );
endinterface

>>> rtl/pid_out_if.sv
// Result item channel of the presence/idle detector.
interface pid_out_if;
    logic            valid;
    logic            ready;
    pid_pkg::t_dist  distance_cm;
    logic            motion_present;
    logic            motion_started;
    logic            motion_ended;
    logic            idle_mode;
    logic            idle_exited;
    logic            idle_entered;
    logic            snooze_fired;
    pid_pkg::t_time  snooze_end_ms;

    modport source (
        output valid, distance_cm, motion_present, motion_started, motion_ended,
               idle_mode, idle_exited, idle_entered, snooze_fired, snooze_end_ms,
        input  ready
    );
    modport sink (
        input  valid, distance_cm, motion_present, motion_started, motion_ended,
               idle_mode, idle_exited, idle_entered, snooze_fired, snooze_end_ms,
        output ready
    );
endinterface

>>> rtl/pid_front.sv
// Input register stage and per-sample echo-to-distance conversion.
module pid_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    pid_in_if.sink              i_item,
    input  logic                i_down_ready,
    output logic                o_down_valid,
    output pid_pkg::t_conv_item o_down_item
);

    logic                                   r_valid;
    logic                                   r_pir;
    pid_pkg::t_echo [pid_pkg::SAMPLE_COUNT-1:0] r_echo;
    logic                                   r_button;
    logic                                   r_running;
    logic                                   r_editing;
    logic                                   r_beeping;
    pid_pkg::t_time                         r_now;
    logic                                   w_take;

    assign i_item.ready = !r_valid || i_down_ready;
    assign w_take       = i_item.valid && i_item.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_pir     <= i_item.pir_detect;
            r_echo    <= {i_item.echo_4, i_item.echo_3, i_item.echo_2,
                          i_item.echo_1, i_item.echo_0};
            r_button  <= i_item.button_pressed;
            r_running <= i_item.timer_running;
            r_editing <= i_item.alarm_editing;
            r_beeping <= i_item.alarm_beeping;
            r_now     <= i_item.now_ms;
        end
    end

    // Convert each sample independently.
    always_comb begin
        o_down_item.pir_detect     = r_pir;
        o_down_item.button_pressed = r_button;
        o_down_item.timer_running  = r_running;
        o_down_item.alarm_editing  = r_editing;
        o_down_item.alarm_beeping  = r_beeping;
        o_down_item.now_ms         = r_now;
        for (int i = 0; i < pid_pkg::SAMPLE_COUNT; i++) begin
            o_down_item.dist_cm[i] = pid_pkg::echo_to_cm(r_echo[i]);
        end
    end

    assign o_down_valid = r_valid;

endmodule

>>> rtl/pid_median.sv
// Median of the converted distances by rank counting.
module pid_median (
    input  pid_pkg::t_dist [pid_pkg::SAMPLE_COUNT-1:0] i_dist,
    output pid_pkg::t_dist                              o_median
);

    logic [pid_pkg::RANK_W:0] w_rank [pid_pkg::SAMPLE_COUNT];

    // Rank = number of samples that sort before this one; ties break by position,
    // so every rank is unique and exactly one sample holds the middle rank.
    always_comb begin
        for (int i = 0; i < pid_pkg::SAMPLE_COUNT; i++) begin
            w_rank[i] = '0;
            for (int j = 0; j < pid_pkg::SAMPLE_COUNT; j++) begin
                if ((i_dist[j] < i_dist[i]) || ((i_dist[j] == i_dist[i]) && (j < i))) begin
                    w_rank[i] = w_rank[i] + 1'b1;
                end
            end
        end
    end

    always_comb begin
        o_median = '0;
        for (int i = 0; i < pid_pkg::SAMPLE_COUNT; i++) begin
            if (w_rank[i] == (pid_pkg::RANK_W + 1)'(pid_pkg::MID_IDX)) begin
                o_median = o_median | i_dist[i];
            end
        end
    end

endmodule

>>> rtl/pid_back.sv
// Distance register, median, presence/idle state update and result register.
module pid_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pid_pkg::t_cfg       i_cfg,
    input  logic                i_up_valid,
    input  pid_pkg::t_conv_item i_up_item,
    output logic                o_up_ready,
    pid_out_if.source           o_result
);

    logic                r_b_valid;
    pid_pkg::t_conv_item r_b;
    logic                r_o_valid;
    pid_pkg::t_result    r_res;
    pid_pkg::t_result    n_res;

    logic                r_presence;
    pid_pkg::t_time      r_last_motion;
    logic                r_idle;
    logic                n_presence;
    pid_pkg::t_time      n_last_motion;
    logic                n_idle;

    pid_pkg::t_dist      w_dist;
    logic                w_out_adv;
    logic                w_b_fire;
    logic                w_act;
    logic                w_window;

    assign w_out_adv  = !r_o_valid || o_result.ready;
    assign o_up_ready = !r_b_valid || w_out_adv;
    assign w_b_fire   = r_b_valid && w_out_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (o_up_ready) begin
            r_b_valid <= i_up_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_up_ready && i_up_valid) begin
            r_b <= i_up_item;
        end
    end

    pid_median u_median (
        .i_dist   (r_b.dist_cm),
        .o_median (w_dist)
    );

    always_comb begin
        n_res         = '0;
        n_presence    = r_presence;
        n_last_motion = r_last_motion;
        n_idle        = r_idle;

        n_res.distance_cm = w_dist;

        // Near motion while beeping snoozes the alarm.
        if (r_b.alarm_beeping && r_b.pir_detect && (w_dist != '0)
            && (w_dist < i_cfg.near_limit_cm)) begin
            n_res.snooze_fired  = 1'b1;
            n_res.snooze_end_ms = r_b.now_ms + i_cfg.snooze_duration_ms;
        end

        w_act = r_b.button_pressed || r_b.timer_running || r_b.alarm_editing;
        if (w_act) begin
            n_last_motion = r_b.now_ms;
            if (n_idle) begin
                n_idle            = 1'b0;
                n_res.idle_exited = 1'b1;
            end
        end

        w_window = r_b.pir_detect && (w_dist > i_cfg.far_low_cm)
                   && (w_dist < i_cfg.far_high_cm);
        if (w_window) begin
            if (!n_presence) begin
                n_presence           = 1'b1;
                n_res.motion_started = 1'b1;
            end
            n_last_motion = r_b.now_ms;
            if (n_idle) begin
                n_idle            = 1'b0;
                n_res.idle_exited = 1'b1;
            end
        end else if (n_presence
                     && ((r_b.now_ms - n_last_motion) > i_cfg.motion_hold_ms)) begin
            n_presence         = 1'b0;
            n_res.motion_ended = 1'b1;
        end

        if (!n_idle && ((r_b.now_ms - n_last_motion) > i_cfg.idle_timeout_ms)) begin
            n_idle             = 1'b1;
            n_res.idle_entered = 1'b1;
        end

        n_res.motion_present = n_presence;
        n_res.idle_mode      = n_idle;
    end

    // Commit state only when the item moves into the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid     <= 1'b0;
            r_presence    <= 1'b0;
            r_last_motion <= '0;
            r_idle        <= 1'b0;
        end else begin
            if (w_out_adv) begin
                r_o_valid <= r_b_valid;
            end
            if (w_b_fire) begin
                r_presence    <= n_presence;
                r_last_motion <= n_last_motion;
                r_idle        <= n_idle;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b_fire) begin
            r_res <= n_res;
        end
    end

    assign o_result.valid          = r_o_valid;
    assign o_result.distance_cm    = r_res.distance_cm;
    assign o_result.motion_present = r_res.motion_present;
    assign o_result.motion_started = r_res.motion_started;
    assign o_result.motion_ended   = r_res.motion_ended;
    assign o_result.idle_mode      = r_res.idle_mode;
    assign o_result.idle_exited    = r_res.idle_exited;
    assign o_result.idle_entered   = r_res.idle_entered;
    assign o_result.snooze_fired   = r_res.snooze_fired;
    assign o_result.snooze_end_ms  = r_res.snooze_end_ms;

`ifndef NO_ASSERTIONS
    a_state_follows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_b_fire |=> (r_presence == r_res.motion_present) && (r_idle == r_res.idle_mode))
        else $error("committed state differs from reported flags");

    a_started_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_res.motion_started) |-> r_res.motion_present)
        else $error("motion started without presence");

    a_ended_absent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_res.motion_ended) |-> !r_res.motion_present)
        else $error("motion ended while presence held");

    a_no_exit_and_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> !(r_res.idle_exited && r_res.idle_entered))
        else $error("idle left and entered on one item");

    a_snooze_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !r_res.snooze_fired) |-> (r_res.snooze_end_ms == '0))
        else $error("snooze end set without snooze");
`endif

endmodule

>>> rtl/presence_idle_detector_unit.sv
// Top level of the presence/idle detector: configuration registers and the two pipeline stages.
//
// Each input item is one sensor poll: a motion-sensor bit, five ultrasonic echo widths in
// microseconds, button and clock activity flags and a wrapping millisecond timestamp. Every
// echo becomes floor(d*17/1000) cm (saturated at 511) and the median of the five is the
// distance. The block then snoozes a beeping alarm on near motion, refreshes the last-motion
// time on activity or windowed motion, holds the presence flag for motion_hold_ms, and enters
// idle mode after idle_timeout_ms of inactivity; all time differences wrap at 32 bits. One
// result item comes out for every input item, in order. Throughput is one item per clock
// while the result side is ready; after the accepting edge the item is held by the input
// register, then the distance register, then the result register, which offers it. The
// rate is set by the result stage, where the presence, last-motion and idle state is read
// and rewritten for each item. The result register decouples the sides: a new item is
// taken while a finished result waits, as long as an earlier register is free. Write
// configuration through i_cfg_we/i_cfg_idx/i_cfg_data only while no item is in
// flight; indexes 0..5 select idle timeout, motion hold, snooze duration, near limit, far
// low and far high bounds, other indexes are ignored. Narrow registers keep the low bits.
module presence_idle_detector_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [pid_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [pid_pkg::CFG_W-1:0]   i_cfg_data,
    pid_in_if.sink                      i_item,
    pid_out_if.source                   o_result
);

    pid_pkg::t_cfg       r_cfg;
    logic                w_mid_valid;
    logic                w_mid_ready;
    pid_pkg::t_conv_item w_mid_item;

    // Configuration registers: decode index, keep the low bits of narrow ones.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.idle_timeout_ms    <= pid_pkg::RST_IDLE_TIMEOUT;
            r_cfg.motion_hold_ms     <= pid_pkg::RST_MOTION_HOLD;
            r_cfg.snooze_duration_ms <= pid_pkg::RST_SNOOZE_DUR;
            r_cfg.near_limit_cm      <= pid_pkg::RST_NEAR_LIMIT;
            r_cfg.far_low_cm         <= pid_pkg::RST_FAR_LOW;
            r_cfg.far_high_cm        <= pid_pkg::RST_FAR_HIGH;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pid_pkg::CFG_IDLE_TIMEOUT: begin
                    r_cfg.idle_timeout_ms <= i_cfg_data;
                end
                pid_pkg::CFG_MOTION_HOLD: begin
                    r_cfg.motion_hold_ms <= i_cfg_data;
                end
                pid_pkg::CFG_SNOOZE_DUR: begin
                    r_cfg.snooze_duration_ms <= i_cfg_data;
                end
                pid_pkg::CFG_NEAR_LIMIT: begin
                    r_cfg.near_limit_cm <= i_cfg_data[pid_pkg::DIST_W-1:0];
                end
                pid_pkg::CFG_FAR_LOW: begin
                    r_cfg.far_low_cm <= i_cfg_data[pid_pkg::DIST_W-1:0];
                end
                pid_pkg::CFG_FAR_HIGH: begin
                    r_cfg.far_high_cm <= i_cfg_data[pid_pkg::DIST_W-1:0];
                end
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    // Stage one: register the poll, convert echoes.
    pid_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (i_item),
        .i_down_ready (w_mid_ready),
        .o_down_valid (w_mid_valid),
        .o_down_item  (w_mid_item)
    );

    // Stage two: hold distances, take the median, advance state, register the result.
    pid_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_up_valid (w_mid_valid),
        .i_up_item  (w_mid_item),
        .o_up_ready (w_mid_ready),
        .o_result   (o_result)
    );

endmodule
